>>> hw/rtl/first_fit_heap_allocator_macros.svh
// assertion macros shared by the heap allocator rtl
// depends on i_clk and i_rst_n being visible in the module that uses them
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
// checked only outside reset
`define FFHA_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
// checked on every edge
`define FFHA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`endif

>>> hw/rtl/ffha_pkg.sv
// types and constants of the first-fit heap allocator
// no dependencies
`timescale 1ns / 1ps
package ffha_pkg;

    // position width: heap offset plus a header and a 16-bit size
    localparam int POS_W = 18;
    localparam int HDR_LEN = 5;
    localparam logic [15:0] MAGIC = 16'd20497;
    localparam logic [7:0] MARK_USED = 8'h59;
    localparam logic [7:0] MARK_FREE = 8'h4E;
    localparam logic [7:0] MARK_BROKEN = 8'h61;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TOO_LARGE   = 3'd1,
        ST_NO_MEMORY   = 3'd2,
        ST_EARLY_FREE  = 3'd3,
        ST_INVALID     = 3'd4,
        ST_DOUBLE_FREE = 3'd5,
        ST_NULL        = 3'd6
    } t_status;

    typedef enum logic [1:0] {BS_AT, BS_B, BS_OFFH} t_base;

    typedef enum logic [2:0] {
        WS_ZERO, WS_USED, WS_FREE, WS_BROKEN, WS_VLO, WS_VHI, WS_MLO, WS_MHI
    } t_wsel;

    typedef enum logic [3:0] {
        LD_NONE, LD_MARK, LD_MARK2, LD_S1LO, LD_S1HI, LD_S2LO, LD_S2HI,
        LD_MLO, LD_MHI
    } t_ld;

    typedef enum logic [3:0] {
        UP_NONE, UP_LOAD, UP_AT_NEXT, UP_B_NEXT, UP_B_SPLIT, UP_AT_B,
        UP_MG_START, UP_STEP_INC, UP_VAL_SIZE, UP_VAL_WHOLE, UP_VAL_FIRST,
        UP_VAL_SPLIT, UP_VAL_SUM
    } t_upd;

    typedef enum logic [5:0] {
        S_CLEAR, S_IDLE, S_M0, S_M1, S_M2, S_DEC,
        S_HW0, S_HW1, S_HW2, S_HW3, S_HW4, S_FA_B, S_FA_V,
        S_W0, S_W1, S_W2, S_W3, S_W4, S_SP1, S_SP2, S_SP3,
        S_F1, S_F2, S_F3, S_F4,
        S_MG0, S_MG1, S_MG2, S_MG3, S_MG4, S_MG5, S_MG6, S_MG7, S_MG8,
        S_MG9, S_MG10, S_MG11, S_FIN
    } t_state;

    typedef struct packed {
        logic    clr;
        logic    rd;
        logic    wr;
        t_base   base;
        logic [2:0] k;
        t_wsel   wsel;
        t_ld     ld;
        t_upd    upd;
        logic    fin;
        t_status st;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
        logic is_free;
        logic is_null;
        logic mark_used;
        logic mark_free;
        logic mark2_free;
        logic magic_ok;
        logic too_large;
        logic first_whole;
        logic size_gt_have;
        logic split_ok;
        logic at_end;
        logic b_end;
        logic off_bad;
        logic steps_done;
        logic out_free;
    } t_dp_stat;

endpackage

>>> hw/rtl/ffha_ifs.sv
// request and response channels of the heap allocator
// no dependencies
`timescale 1ns / 1ps
interface ffha_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [11:0] request_size;
    logic [11:0] block_offset;
    logic        null_ref;
    modport source (output valid, action, request_size, block_offset, null_ref,
                    input ready);
    modport sink (input valid, action, request_size, block_offset, null_ref,
                  output ready);
endinterface

interface ffha_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [11:0] granted_offset;
    modport source (output valid, status, granted_offset, input ready);
    modport sink (input valid, status, granted_offset, output ready);
endinterface

>>> hw/rtl/ffha_datapath.sv
// heap memory, header registers, address arithmetic and result register
// depends on ffha_pkg, ffha_ifs and the assertion macros
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_macros.svh"
module ffha_datapath import ffha_pkg::*; #(
    parameter int HEAP_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    input  logic        i_action,
    input  logic [11:0] i_request_size,
    input  logic [11:0] i_block_offset,
    input  logic        i_null_ref,
    ffha_rsp_if.source  o_rsp
);
    localparam int AW = $clog2(HEAP_BYTES);
    localparam logic [POS_W-1:0] HEAP_P = POS_W'(HEAP_BYTES);
    localparam logic [POS_W-1:0] ALLOC_MAX = POS_W'(HEAP_BYTES - HDR_LEN);
    localparam logic [POS_W-1:0] FIRST_MAX = POS_W'(HEAP_BYTES - 2 * HDR_LEN);
    localparam logic [POS_W-1:0] STEP_LIM = POS_W'(2 * HEAP_BYTES);
    localparam logic [15:0] WHOLE_SZ = 16'(HEAP_BYTES - HDR_LEN);
    localparam logic [AW-1:0] CLR_LAST = AW'(HEAP_BYTES - 1);
    localparam logic [POS_W-1:0] HDR_P = POS_W'(HDR_LEN);
    localparam logic [15:0] HDR_16 = 16'(HDR_LEN);

    logic [7:0]       r_mem [HEAP_BYTES];
    logic [7:0]       r_rdata;
    logic             r_roob;
    logic             r_action;
    logic [11:0]      r_size;
    logic [11:0]      r_off;
    logic             r_null;
    logic [POS_W-1:0] r_at;
    logic [POS_W-1:0] r_b;
    logic [POS_W-1:0] r_steps;
    logic [15:0]      r_s1;
    logic [15:0]      r_s2;
    logic [15:0]      r_m16;
    logic [15:0]      r_val;
    logic [7:0]       r_mark;
    logic [7:0]       r_mark2;
    logic [AW-1:0]    r_clr;
    logic             r_ovalid;
    t_status          r_ostatus;
    logic [11:0]      r_ogrant;

    logic [POS_W-1:0] w_base;
    logic [POS_W-1:0] w_addr;
    logic             w_inr;
    logic [7:0]       w_wdata;
    logic [7:0]       w_rd8;
    logic [POS_W-1:0] w_next;

    // byte address of the current access
    always_comb begin
        case (i_cmd.base)
            BS_AT:   w_base = r_at;
            BS_B:    w_base = r_b;
            BS_OFFH: w_base = POS_W'(r_off) - HDR_P;
            default: w_base = r_at;
        endcase
        w_addr = w_base + POS_W'(i_cmd.k);
        w_inr = w_addr < HEAP_P;
    end

    // write byte select
    always_comb begin
        case (i_cmd.wsel)
            WS_USED:   w_wdata = MARK_USED;
            WS_FREE:   w_wdata = MARK_FREE;
            WS_BROKEN: w_wdata = MARK_BROKEN;
            WS_VLO:    w_wdata = r_val[7:0];
            WS_VHI:    w_wdata = r_val[15:8];
            WS_MLO:    w_wdata = MAGIC[7:0];
            WS_MHI:    w_wdata = MAGIC[15:8];
            default:   w_wdata = 8'h00;
        endcase
    end

    // reads past the heap end give zero
    assign w_rd8 = r_roob ? 8'h00 : r_rdata;
    assign w_next = r_at + HDR_P + POS_W'(r_s1);

    // heap memory, one access a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_mem[r_clr] <= 8'h00;
        end else if (i_cmd.wr && w_inr) begin
            r_mem[w_addr[AW-1:0]] <= w_wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[w_addr[AW-1:0]];
            r_roob <= !w_inr;
        end
    end

    // capture of read bytes
    always_ff @(posedge i_clk) begin
        case (i_cmd.ld)
            LD_MARK:  r_mark <= w_rd8;
            LD_MARK2: r_mark2 <= w_rd8;
            LD_S1LO:  r_s1[7:0] <= w_rd8;
            LD_S1HI:  r_s1[15:8] <= w_rd8;
            LD_S2LO:  r_s2[7:0] <= w_rd8;
            LD_S2HI:  r_s2[15:8] <= w_rd8;
            LD_MLO:   r_m16[7:0] <= w_rd8;
            LD_MHI:   r_m16[15:8] <= w_rd8;
            default: ;
        endcase
    end

    // request fields, walk pointers and header values
    always_ff @(posedge i_clk) begin
        case (i_cmd.upd)
            UP_LOAD: begin
                r_action <= i_action;
                r_size <= i_request_size;
                r_off <= i_block_offset;
                r_null <= i_null_ref;
                r_at <= '0;
            end
            UP_AT_NEXT:   r_at <= w_next;
            UP_B_NEXT:    r_b <= w_next;
            UP_B_SPLIT:   r_b <= r_at + HDR_P + POS_W'(r_size);
            UP_AT_B:      r_at <= r_b;
            UP_MG_START: begin
                r_at <= '0;
                r_steps <= '0;
            end
            UP_STEP_INC:  r_steps <= r_steps + POS_W'(1);
            UP_VAL_SIZE:  r_val <= 16'(r_size);
            UP_VAL_WHOLE: r_val <= WHOLE_SZ;
            UP_VAL_FIRST: r_val <= 16'(FIRST_MAX - POS_W'(r_size));
            UP_VAL_SPLIT: r_val <= r_s1 - 16'(r_size) - HDR_16;
            UP_VAL_SUM:   r_val <= r_s1 + r_s2 + HDR_16;
            default: ;
        endcase
    end

    // clearing sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_ostatus <= i_cmd.st;
            r_ogrant <= (i_cmd.st == ST_OK && !r_action) ? 12'(r_at + HDR_P) : 12'd0;
        end
    end

    assign o_rsp.valid = r_ovalid;
    assign o_rsp.status = r_ostatus;
    assign o_rsp.granted_offset = r_ogrant;

    // status toward the controller
    always_comb begin
        o_stat.clr_done = r_clr == CLR_LAST;
        o_stat.is_free = r_action;
        o_stat.is_null = r_null;
        o_stat.mark_used = r_mark == MARK_USED;
        o_stat.mark_free = r_mark == MARK_FREE;
        o_stat.mark2_free = r_mark2 == MARK_FREE;
        o_stat.magic_ok = r_m16 == MAGIC;
        o_stat.too_large = POS_W'(r_size) > ALLOC_MAX;
        o_stat.first_whole = POS_W'(r_size) > FIRST_MAX;
        o_stat.size_gt_have = 16'(r_size) > r_s1;
        o_stat.split_ok = (r_s1 - 16'(r_size)) >= HDR_16;
        o_stat.at_end = r_at >= HEAP_P;
        o_stat.b_end = r_b >= HEAP_P;
        o_stat.off_bad = (POS_W'(r_off) < HDR_P) || (POS_W'(r_off) >= HEAP_P);
        o_stat.steps_done = r_steps >= STEP_LIM;
        o_stat.out_free = !r_ovalid || o_rsp.ready;
    end

    // a walk step always moves forward
    `FFHA_ASSERT_RST(a_walk_fwd, (i_cmd.upd == UP_AT_NEXT) |=> (r_at > $past(r_at)), "walk did not advance")
    // an unread result is never overwritten
    `FFHA_ASSERT_RST(a_no_overwrite, (i_cmd.fin && r_ovalid) |-> o_rsp.ready, "result overwritten")
    // the clearing sweep never collides with a write
    `FFHA_ASSERT_ALWAYS(a_clr_excl, i_cmd.clr |-> !i_cmd.wr, "clear and write together")
endmodule

>>> hw/rtl/ffha_ctrl.sv
// sequencer of the heap allocator: clear sweep, header walk, split and merge
// depends on ffha_pkg and the assertion macros
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_macros.svh"
module ffha_ctrl import ffha_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_in_ready
);
    t_state  r_state, n_state;
    t_status r_st, n_st;
    t_base   r_hbase, n_hbase;
    logic    r_hmark, n_hmark;
    logic    r_hlast, n_hlast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_st <= n_st;
        r_hbase <= n_hbase;
        r_hmark <= n_hmark;
        r_hlast <= n_hlast;
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_st = r_st;
        n_hbase = r_hbase;
        n_hmark = r_hmark;
        n_hlast = r_hlast;
        case (r_state)
            S_CLEAR: if (i_stat.clr_done) n_state = S_IDLE;
            S_IDLE:  if (i_in_valid) n_state = S_M0;
            S_M0:    n_state = S_M1;
            S_M1:    n_state = S_M2;
            S_M2:    n_state = S_DEC;
            S_DEC: begin
                if (i_stat.is_free) begin
                    if (!i_stat.magic_ok) begin
                        n_st = ST_EARLY_FREE;
                        n_state = S_FIN;
                    end else if (i_stat.is_null) begin
                        n_st = ST_NULL;
                        n_state = S_FIN;
                    end else if (i_stat.off_bad) begin
                        n_st = ST_INVALID;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_F1;
                    end
                end else if (i_stat.too_large) begin
                    n_st = ST_TOO_LARGE;
                    n_state = S_FIN;
                end else if (!i_stat.magic_ok) begin
                    n_hbase = BS_AT;
                    n_hmark = 1'b1;
                    n_hlast = i_stat.first_whole;
                    n_state = S_HW0;
                end else begin
                    n_state = S_W0;
                end
            end
            S_HW0: n_state = S_HW1;
            S_HW1: n_state = S_HW2;
            S_HW2: n_state = S_HW3;
            S_HW3: n_state = S_HW4;
            S_HW4: begin
                if (r_hlast) begin
                    n_st = ST_OK;
                    n_state = S_FIN;
                end else begin
                    n_state = S_FA_B;
                end
            end
            S_FA_B: n_state = S_FA_V;
            S_FA_V, S_SP3: begin
                n_hbase = BS_B;
                n_hmark = 1'b0;
                n_hlast = 1'b1;
                n_state = S_HW0;
            end
            S_W0: begin
                if (i_stat.at_end) begin
                    n_st = ST_NO_MEMORY;
                    n_state = S_FIN;
                end else begin
                    n_state = S_W1;
                end
            end
            S_W1: n_state = S_W2;
            S_W2: n_state = S_W3;
            S_W3: n_state = S_W4;
            S_W4: begin
                if (i_stat.mark_used || (i_stat.mark_free && i_stat.size_gt_have)) begin
                    n_state = S_W0;
                end else if (!i_stat.mark_free) begin
                    n_st = ST_NO_MEMORY;
                    n_state = S_FIN;
                end else if (i_stat.split_ok) begin
                    n_state = S_SP1;
                end else begin
                    n_st = ST_OK;
                    n_state = S_FIN;
                end
            end
            S_SP1: n_state = S_SP2;
            S_SP2: n_state = S_SP3;
            S_F1:  n_state = S_F2;
            S_F2:  n_state = S_F3;
            S_F3:  n_state = S_F4;
            S_F4: begin
                if (!i_stat.magic_ok) begin
                    n_st = ST_INVALID;
                end else if (i_stat.mark_used) begin
                    n_st = ST_OK;
                end else begin
                    n_st = ST_DOUBLE_FREE;
                end
                n_state = S_MG0;
            end
            S_MG0: begin
                if (i_stat.at_end || i_stat.steps_done) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_MG1;
                end
            end
            S_MG1: n_state = S_MG2;
            S_MG2: n_state = S_MG3;
            S_MG3: n_state = S_MG4;
            S_MG4: begin
                if (i_stat.b_end) begin
                    n_state = S_FIN;
                end else if (!i_stat.mark_free) begin
                    n_state = S_MG0;
                end else begin
                    n_state = S_MG5;
                end
            end
            S_MG5: n_state = S_MG6;
            S_MG6: n_state = i_stat.mark2_free ? S_MG7 : S_MG0;
            S_MG7: n_state = S_MG8;
            S_MG8: n_state = S_MG9;
            S_MG9: n_state = S_MG10;
            S_MG10: n_state = S_MG11;
            S_MG11: n_state = S_MG0;
            S_FIN: if (i_stat.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_cmd.st = r_st;
        case (r_state)
            S_CLEAR: o_cmd.clr = 1'b1;
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.upd = UP_LOAD;
            end
            // magic of the first header
            S_M0: begin
                o_cmd.rd = 1'b1;
                o_cmd.k = 3'd3;
            end
            S_M1: begin
                o_cmd.ld = LD_MLO;
                o_cmd.rd = 1'b1;
                o_cmd.k = 3'd4;
            end
            S_M2: o_cmd.ld = LD_MHI;
            S_DEC: begin
                if (i_stat.is_free) begin
                    o_cmd.rd = 1'b1;
                    o_cmd.base = BS_OFFH;
                    o_cmd.k = 3'd3;
                end else if (i_stat.first_whole) begin
                    o_cmd.upd = UP_VAL_WHOLE;
                end else begin
                    o_cmd.upd = UP_VAL_SIZE;
                end
            end
            // five-byte header write
            S_HW0: begin
                o_cmd.wr = 1'b1;
                o_cmd.base = r_hbase;
                o_cmd.wsel = r_hmark ? WS_USED : WS_FREE;
            end
            S_HW1: begin
                o_cmd.wr = 1'b1;
                o_cmd.base = r_hbase;
                o_cmd.k = 3'd1;
                o_cmd.wsel = WS_VLO;
            end
            S_HW2: begin
                o_cmd.wr = 1'b1;
                o_cmd.base = r_hbase;
                o_cmd.k = 3'd2;
                o_cmd.wsel = WS_VHI;
            end
            S_HW3: begin
                o_cmd.wr = 1'b1;
                o_cmd.base = r_hbase;
                o_cmd.k = 3'd3;
                o_cmd.wsel = WS_MLO;
            end
            S_HW4: begin
                o_cmd.wr = 1'b1;
                o_cmd.base = r_hbase;
                o_cmd.k = 3'd4;
                o_cmd.wsel = WS_MHI;
            end
            S_FA_B: o_cmd.upd = UP_B_SPLIT;
            S_FA_V: o_cmd.upd = UP_VAL_FIRST;
            // first-fit header walk
            S_W0: o_cmd.rd = !i_stat.at_end;
            S_W1: begin
                o_cmd.ld = LD_MARK;
                o_cmd.rd = 1'b1;
                o_cmd.k = 3'd1;
            end
            S_W2: begin
                o_cmd.ld = LD_S1LO;
                o_cmd.rd = 1'b1;
                o_cmd.k = 3'd2;
            end
            S_W3: o_cmd.ld = LD_S1HI;
            S_W4: begin
                if (i_stat.mark_used || (i_stat.mark_free && i_stat.size_gt_have)) begin
                    o_cmd.upd = UP_AT_NEXT;
                end else if (i_stat.mark_free) begin
                    o_cmd.wr = 1'b1;
                    o_cmd.wsel = WS_USED;
                    if (i_stat.split_ok) o_cmd.upd = UP_VAL_SIZE;
                end
            end
            // split: shrink the granted block
            S_SP1: begin
                o_cmd.wr = 1'b1;
                o_cmd.k = 3'd1;
                o_cmd.wsel = WS_VLO;
            end
            S_SP2: begin
                o_cmd.wr = 1'b1;
                o_cmd.k = 3'd2;
                o_cmd.wsel = WS_VHI;
                o_cmd.upd = UP_B_SPLIT;
            end
            S_SP3: o_cmd.upd = UP_VAL_SPLIT;
            // free: check magic and in-use mark
            S_F1: begin
                o_cmd.ld = LD_MLO;
                o_cmd.rd = 1'b1;
                o_cmd.base = BS_OFFH;
                o_cmd.k = 3'd4;
            end
            S_F2: begin
                o_cmd.ld = LD_MHI;
                o_cmd.rd = 1'b1;
                o_cmd.base = BS_OFFH;
            end
            S_F3: o_cmd.ld = LD_MARK;
            S_F4: begin
                o_cmd.upd = UP_MG_START;
                if (i_stat.magic_ok && i_stat.mark_used) begin
                    o_cmd.wr = 1'b1;
                    o_cmd.base = BS_OFFH;
                    o_cmd.wsel = WS_FREE;
                end
            end
            // merge pass over header pairs
            S_MG0: begin
                if (!(i_stat.at_end || i_stat.steps_done)) begin
                    o_cmd.rd = 1'b1;
                    o_cmd.k = 3'd1;
                    o_cmd.upd = UP_STEP_INC;
                end
            end
            S_MG1: begin
                o_cmd.ld = LD_S1LO;
                o_cmd.rd = 1'b1;
                o_cmd.k = 3'd2;
            end
            S_MG2: begin
                o_cmd.ld = LD_S1HI;
                o_cmd.rd = 1'b1;
            end
            S_MG3: begin
                o_cmd.ld = LD_MARK;
                o_cmd.upd = UP_B_NEXT;
            end
            S_MG4: begin
                if (!i_stat.b_end) begin
                    if (i_stat.mark_free) begin
                        o_cmd.rd = 1'b1;
                        o_cmd.base = BS_B;
                    end else begin
                        o_cmd.upd = UP_AT_B;
                    end
                end
            end
            S_MG5: o_cmd.ld = LD_MARK2;
            S_MG6: begin
                if (i_stat.mark2_free) begin
                    o_cmd.rd = 1'b1;
                    o_cmd.base = BS_B;
                    o_cmd.k = 3'd1;
                end else begin
                    o_cmd.upd = UP_AT_B;
                end
            end
            S_MG7: begin
                o_cmd.ld = LD_S2LO;
                o_cmd.rd = 1'b1;
                o_cmd.base = BS_B;
                o_cmd.k = 3'd2;
            end
            S_MG8: o_cmd.ld = LD_S2HI;
            S_MG9: begin
                o_cmd.wr = 1'b1;
                o_cmd.base = BS_B;
                o_cmd.k = 3'd4;
                o_cmd.wsel = WS_BROKEN;
                o_cmd.upd = UP_VAL_SUM;
            end
            S_MG10: begin
                o_cmd.wr = 1'b1;
                o_cmd.k = 3'd1;
                o_cmd.wsel = WS_VLO;
            end
            S_MG11: begin
                o_cmd.wr = 1'b1;
                o_cmd.k = 3'd2;
                o_cmd.wsel = WS_VHI;
            end
            S_FIN: o_cmd.fin = i_stat.out_free;
            default: ;
        endcase
    end

    // the clearing sweep runs to its end before any request
    `FFHA_ASSERT_RST(a_clear_holds, (r_state == S_CLEAR && !i_stat.clr_done) |=> (r_state == S_CLEAR), "clear sweep cut short")
    // the heap is never written while waiting for a request
    `FFHA_ASSERT_RST(a_idle_no_wr, (r_state == S_IDLE) |-> !o_cmd.wr, "write while idle")
    // a finished result waits until the output slot frees
    `FFHA_ASSERT_RST(a_fin_wait, (r_state == S_FIN && !i_stat.out_free) |=> (r_state == S_FIN), "result dropped")
endmodule

>>> hw/rtl/first_fit_heap_allocator.sv
// First-fit heap allocator over a byte heap of HEAP_BYTES bytes.
// Request channel i_req (valid/ready): action 0 allocates request_size bytes,
// action 1 frees the user area at block_offset (null_ref marks a null free).
// Response channel o_rsp (valid/ready): one beat per request with status and
// granted_offset (user-area offset on a successful allocate, else 0).
// Requests are handled one at a time; i_req.ready is high only while idle.
// Each request first reads the first header's magic and decodes, then an
// allocate walks the headers in order and writes the headers it needs, and a
// checked free runs a merge pass over the headers; the result register is
// loaded last. The heap memory is single-port, one byte per cycle.
// After reset a clearing sweep zeroes the heap, one byte a cycle; no request
// is taken until it ends.
// The response sits in an output register: when the receiver stalls, the
// finished request holds there and the next request is still accepted, but its
// result waits until the earlier beat has been taken.
// depends on ffha_pkg, ffha_ifs, ffha_ctrl and ffha_datapath
`timescale 1ns / 1ps
module first_fit_heap_allocator import ffha_pkg::*; #(
    parameter int HEAP_BYTES = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ffha_req_if.sink   i_req,
    ffha_rsp_if.source o_rsp
);
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;

    // sequencer
    ffha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_ready (w_in_ready)
    );

    assign i_req.ready = w_in_ready;

    // heap memory and arithmetic
    ffha_datapath #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_action       (i_req.action),
        .i_request_size (i_req.request_size),
        .i_block_offset (i_req.block_offset),
        .i_null_ref     (i_req.null_ref),
        .o_rsp          (o_rsp)
    );
endmodule
